FILE: rtl/core/text_cell_line_rasterizer_assert.svh
// Assertion macros for the text-cell line rasterizer.
`ifndef TEXT_CELL_LINE_RASTERIZER_ASSERT_SVH
`define TEXT_CELL_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, clocked on aclk, off while in reset.
`define TCLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on aclk, off while in reset.
`define TCLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tclr_pkg.sv
// Package: grid size, field widths, codes and types of the line rasterizer.
package tclr_pkg;

    // Character grid
    localparam int unsigned COLUMNS = 80;
    localparam int unsigned ROWS    = 25;

    // Field widths
    localparam int unsigned X_W     = 7;
    localparam int unsigned Y_W     = 6;
    localparam int unsigned ADDR_W  = 11;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned COLOR_W = 4;
    localparam int unsigned GLYPH_W = 8;

    // Internal state widths
    localparam int unsigned CUR_X_W  = 8;
    localparam int unsigned CUR_Y_W  = 7;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned ERR_W    = 10;
    localparam int unsigned SGAIN_W  = 9;
    localparam int unsigned ATTR_W   = 12;
    localparam int unsigned PROD_W   = 14;

    // Beat widths
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 40;

    // Item kind carried on s_tuser
    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_STEP = 1'b1
    } mode_t;

    // Step directions and major axis, fixed at load
    typedef struct packed {
        logic y_major;
        logic y_neg;
        logic x_neg;
    } step_signs_t;

endpackage

FILE: rtl/core/text_cell_line_rasterizer.sv
// Top level: Bresenham line generator for a text-mode character grid.

// A load beat (s_tuser = 0) latches two endpoints, a glyph and a foreground
// colour and gives no result; each later step beat (s_tuser = 1) emits one
// point of the line with its cell address and cell word, the final point
// flagged by m_tlast and off-grid points by m_tuser (address then zero).
// A line has (major-axis length + 1) points; steps while no line is active
// are swallowed. One beat is taken every clock: the error term update is a
// single add and sign test between the state registers, and the result
// register frees as it is read, so s_tready stays high unless a result is
// held by m_tready low. A step's result shows in the next cycle.
// Background colour: cfg_we/cfg_wdata; user writes only while idle, unchecked.

`include "text_cell_line_rasterizer_assert.svh"

module text_cell_line_rasterizer (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: background colour
    input  logic                             cfg_we,
    input  logic [tclr_pkg::COLOR_W-1:0]     cfg_wdata,
    // input channel
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_x[6:0] start_y[12:7] end_x[19:13] end_y[25:20] fg_color[29:26]
    // glyph[37:30], zero above
    input  logic [tclr_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode[0]
    input  logic                             s_tuser,
    // result channel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // point_x[6:0] point_y[12:7] cell_address[23:13] cell_word[39:24]
    output logic [tclr_pkg::M_TDATA_W-1:0]   m_tdata,
    // off_screen[0]
    output logic                             m_tuser,
    output logic                             m_tlast
);

    // ------------------------------------------------------------------
    // Registers
    logic [tclr_pkg::COLOR_W-1:0]   bg_color_reg;
    logic                           busy_reg,        busy_next;
    logic [tclr_pkg::CUR_X_W-1:0]   cur_x_reg,       cur_x_next;
    logic [tclr_pkg::CUR_Y_W-1:0]   cur_y_reg,       cur_y_next;
    logic [tclr_pkg::COUNT_W-1:0]   points_left_reg, points_left_next;
    logic signed [tclr_pkg::ERR_W-1:0] error_reg,    error_next;
    logic [tclr_pkg::SGAIN_W-1:0]   straight_reg,    straight_next;
    logic signed [tclr_pkg::ERR_W-1:0] diagonal_reg, diagonal_next;
    tclr_pkg::step_signs_t          signs_reg,       signs_next;
    logic [tclr_pkg::ATTR_W-1:0]    attrs_reg,       attrs_next;

    logic                           m_tvalid_reg,    m_tvalid_next;
    logic [tclr_pkg::M_TDATA_W-1:0] m_tdata_reg,     m_tdata_next;
    logic                           m_tuser_reg,     m_tuser_next;
    logic                           m_tlast_reg,     m_tlast_next;

    // ------------------------------------------------------------------
    // Handshake
    logic accept;
    logic is_step;
    logic emit;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_step  = (tclr_pkg::mode_t'(s_tuser) == tclr_pkg::MODE_STEP);
    assign emit     = accept && is_step && busy_reg;

    // ------------------------------------------------------------------
    // Input fields
    logic [tclr_pkg::X_W-1:0]     in_start_x, in_end_x;
    logic [tclr_pkg::Y_W-1:0]     in_start_y, in_end_y;
    logic [tclr_pkg::COLOR_W-1:0] in_fg;
    logic [tclr_pkg::GLYPH_W-1:0] in_glyph;

    assign in_start_x = s_tdata[6:0];
    assign in_start_y = s_tdata[12:7];
    assign in_end_x   = s_tdata[19:13];
    assign in_end_y   = s_tdata[25:20];
    assign in_fg      = s_tdata[29:26];
    assign in_glyph   = s_tdata[37:30];

    // ------------------------------------------------------------------
    // Load set-up: signs, major axis, error terms
    logic [tclr_pkg::X_W:0]       dx_s;
    logic [tclr_pkg::Y_W:0]       dy_s;
    logic [tclr_pkg::X_W-1:0]     dx_abs;
    logic [tclr_pkg::Y_W-1:0]     dy_abs;
    logic                         ld_y_major;
    logic [tclr_pkg::X_W-1:0]     major, minor;
    logic signed [tclr_pkg::ERR_W-1:0] ld_error;

    always_comb begin
        dx_s       = {1'b0, in_end_x} - {1'b0, in_start_x};
        dy_s       = {1'b0, in_end_y} - {1'b0, in_start_y};
        dx_abs     = dx_s[tclr_pkg::X_W] ? tclr_pkg::X_W'(-dx_s) : dx_s[tclr_pkg::X_W-1:0];
        dy_abs     = dy_s[tclr_pkg::Y_W] ? tclr_pkg::Y_W'(-dy_s) : dy_s[tclr_pkg::Y_W-1:0];
        ld_y_major = dx_abs < tclr_pkg::X_W'(dy_abs);
        major      = ld_y_major ? tclr_pkg::X_W'(dy_abs) : dx_abs;
        minor      = ld_y_major ? dx_abs : tclr_pkg::X_W'(dy_abs);
        ld_error   = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
    end

    // ------------------------------------------------------------------
    // Current point: grid test, address, cell word
    logic                          off_screen;
    logic [tclr_pkg::CUR_Y_W-1:0]  row_idx;
    logic [tclr_pkg::PROD_W-1:0]   addr_full;
    logic [tclr_pkg::ADDR_W-1:0]   cell_addr;
    logic [tclr_pkg::WORD_W-1:0]   cell_word;

    always_comb begin
        off_screen = (cur_x_reg >= tclr_pkg::CUR_X_W'(tclr_pkg::COLUMNS))
                  || (cur_y_reg == '0)
                  || (cur_y_reg > tclr_pkg::CUR_Y_W'(tclr_pkg::ROWS));
        row_idx    = cur_y_reg - tclr_pkg::CUR_Y_W'(1);
        addr_full  = tclr_pkg::PROD_W'(tclr_pkg::COLUMNS) * tclr_pkg::PROD_W'(row_idx)
                   + tclr_pkg::PROD_W'(cur_x_reg);
        cell_addr  = off_screen ? '0 : addr_full[tclr_pkg::ADDR_W-1:0];
        cell_word  = {bg_color_reg, attrs_reg};
    end

    // ------------------------------------------------------------------
    // Step: diagonal or straight move picked by the error sign
    logic [tclr_pkg::CUR_X_W-1:0] step_x, moved_x;
    logic [tclr_pkg::CUR_Y_W-1:0] step_y, moved_y;

    assign step_x  = signs_reg.x_neg ? '1 : tclr_pkg::CUR_X_W'(1);
    assign step_y  = signs_reg.y_neg ? '1 : tclr_pkg::CUR_Y_W'(1);
    assign moved_x = cur_x_reg + step_x;
    assign moved_y = cur_y_reg + step_y;

    // ------------------------------------------------------------------
    // Next state
    always_comb begin
        busy_next        = busy_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        points_left_next = points_left_reg;
        error_next       = error_reg;
        straight_next    = straight_reg;
        diagonal_next    = diagonal_reg;
        signs_next       = signs_reg;
        attrs_next       = attrs_reg;

        if (accept && !is_step) begin
            cur_x_next        = tclr_pkg::CUR_X_W'(in_start_x);
            cur_y_next        = tclr_pkg::CUR_Y_W'(in_start_y);
            straight_next     = {1'b0, minor, 1'b0};
            error_next        = ld_error;
            diagonal_next     = ld_error - $signed({3'b000, major});
            signs_next.x_neg  = dx_s[tclr_pkg::X_W];
            signs_next.y_neg  = dy_s[tclr_pkg::Y_W];
            signs_next.y_major = ld_y_major;
            points_left_next  = tclr_pkg::COUNT_W'(major) + tclr_pkg::COUNT_W'(1);
            attrs_next        = {in_fg, in_glyph};
            busy_next         = 1'b1;
        end else if (emit) begin
            if (!error_reg[tclr_pkg::ERR_W-1]) begin
                cur_x_next = moved_x;
                cur_y_next = moved_y;
                error_next = error_reg + diagonal_reg;
            end else begin
                if (signs_reg.y_major) begin
                    cur_y_next = moved_y;
                end else begin
                    cur_x_next = moved_x;
                end
                error_next = error_reg + $signed({1'b0, straight_reg});
            end
            points_left_next = points_left_reg - tclr_pkg::COUNT_W'(1);
            busy_next        = (points_left_reg != tclr_pkg::COUNT_W'(1));
        end
    end

    // ------------------------------------------------------------------
    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {cell_word, cell_addr,
                             cur_y_reg[tclr_pkg::Y_W-1:0], cur_x_reg[tclr_pkg::X_W-1:0]};
            m_tuser_next  = off_screen;
            m_tlast_next  = (points_left_reg == tclr_pkg::COUNT_W'(1));
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Clocked state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_color_reg    <= '0;
            busy_reg        <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            points_left_reg <= '0;
            error_reg       <= '0;
            straight_reg    <= '0;
            diagonal_reg    <= '0;
            signs_reg       <= '0;
            attrs_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                bg_color_reg <= cfg_wdata;
            end
            busy_reg        <= busy_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            points_left_reg <= points_left_next;
            error_reg       <= error_next;
            straight_reg    <= straight_next;
            diagonal_reg    <= diagonal_next;
            signs_reg       <= signs_next;
            attrs_reg       <= attrs_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Assertions
    `TCLR_ASSERT_NOW(a_busy_has_points, busy_reg, points_left_reg != '0,
        "active line with no points left")
    `TCLR_ASSERT_NEXT(a_last_ends_line,
        emit && (points_left_reg == tclr_pkg::COUNT_W'(1)), !busy_reg,
        "line still active after its last point")
    `TCLR_ASSERT_NEXT(a_idle_step_silent, accept && is_step && !busy_reg, !m_tvalid_reg,
        "step while idle gave a result")
    `TCLR_ASSERT_NOW(a_off_grid_no_addr, m_tvalid_reg && m_tuser_reg,
        m_tdata_reg[23:13] == '0, "off-grid point carries an address")

endmodule

FILE: tb/sv/text_cell_line_rasterizer_test.sv
// Self-checking testbench for the text-cell line rasterizer, with a line predictor.
`timescale 1ns / 1ps

module text_cell_line_rasterizer_test;

    // One input beat, unpacked
    typedef struct {
        tclr_pkg::mode_t              mode;
        logic [tclr_pkg::X_W-1:0]     from_x;
        logic [tclr_pkg::Y_W-1:0]     from_y;
        logic [tclr_pkg::X_W-1:0]     to_x;
        logic [tclr_pkg::Y_W-1:0]     to_y;
        logic [tclr_pkg::COLOR_W-1:0] fg;
        logic [tclr_pkg::GLYPH_W-1:0] glyph;
    } line_beat_t;

    // One emitted point
    typedef struct {
        logic [tclr_pkg::X_W-1:0]    x;
        logic [tclr_pkg::Y_W-1:0]    y;
        logic [tclr_pkg::ADDR_W-1:0] addr;
        logic [tclr_pkg::WORD_W-1:0] word;
        logic                        off;
        logic                        last;
    } grid_point_t;

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [tclr_pkg::COLOR_W-1:0]   cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tclr_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                           s_tuser   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tclr_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    text_cell_line_rasterizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    line_beat_t  beats_pending[$];
    line_beat_t  beat_on_bus;
    grid_point_t points_due[$];
    int          mismatches = 0;
    bit          calm       = 1'b0;   // no idling on either side
    bit          hold_req   = 1'b0;   // ask the receiver for a long hold-off
    int          hold_left  = 0;

    // Predictor state
    logic [tclr_pkg::COLOR_W-1:0]       bg_model = '0;
    logic                               ln_busy  = 1'b0;
    logic [tclr_pkg::CUR_X_W-1:0]       ln_x     = '0;
    logic [tclr_pkg::CUR_Y_W-1:0]       ln_y     = '0;
    logic [tclr_pkg::COUNT_W-1:0]       ln_left  = '0;
    logic signed [tclr_pkg::ERR_W-1:0]  ln_err   = '0;
    logic [tclr_pkg::SGAIN_W-1:0]       ln_sgain = '0;
    logic signed [tclr_pkg::ERR_W-1:0]  ln_dgain = '0;
    tclr_pkg::step_signs_t              ln_signs = '0;
    logic [tclr_pkg::ATTR_W-1:0]        ln_attrs = '0;

    // Bresenham step on the predictor; queues the point a step beat produces
    task automatic rasterize_beat(input line_beat_t b);
        int dx, dy, major, minor;
        grid_point_t p;
        logic [tclr_pkg::CUR_X_W-1:0] sx;
        logic [tclr_pkg::CUR_Y_W-1:0] sy;
        if (b.mode == tclr_pkg::MODE_LOAD) begin
            dx = int'(b.to_x) - int'(b.from_x);
            dy = int'(b.to_y) - int'(b.from_y);
            ln_signs = '0;
            if (dx < 0) begin
                dx = -dx;
                ln_signs.x_neg = 1'b1;
            end
            if (dy < 0) begin
                dy = -dy;
                ln_signs.y_neg = 1'b1;
            end
            if (dx >= dy) begin
                major = dx;
                minor = dy;
            end else begin
                major = dy;
                minor = dx;
                ln_signs.y_major = 1'b1;
            end
            ln_x     = tclr_pkg::CUR_X_W'(b.from_x);
            ln_y     = tclr_pkg::CUR_Y_W'(b.from_y);
            ln_sgain = tclr_pkg::SGAIN_W'(2 * minor);
            ln_err   = tclr_pkg::ERR_W'(2 * minor - major);
            ln_dgain = tclr_pkg::ERR_W'(2 * minor - 2 * major);
            ln_left  = tclr_pkg::COUNT_W'(major + 1);
            ln_attrs = {b.fg, b.glyph};
            ln_busy  = 1'b1;
        end else if (ln_busy) begin
            p.off  = (ln_x >= tclr_pkg::COLUMNS) || (ln_y < 1) || (ln_y > tclr_pkg::ROWS);
            p.x    = ln_x[tclr_pkg::X_W-1:0];
            p.y    = ln_y[tclr_pkg::Y_W-1:0];
            p.addr = p.off ? '0 :
                     tclr_pkg::ADDR_W'(tclr_pkg::COLUMNS * (int'(ln_y) - 1) + int'(ln_x));
            p.word = {bg_model, ln_attrs};
            p.last = (ln_left == 1);
            points_due.push_back(p);
            sx = ln_signs.x_neg ? {tclr_pkg::CUR_X_W{1'b1}} : tclr_pkg::CUR_X_W'(1);
            sy = ln_signs.y_neg ? {tclr_pkg::CUR_Y_W{1'b1}} : tclr_pkg::CUR_Y_W'(1);
            if (ln_err >= 0) begin
                ln_x   = ln_x + sx;
                ln_y   = ln_y + sy;
                ln_err = ln_err + ln_dgain;
            end else begin
                if (ln_signs.y_major)
                    ln_y = ln_y + sy;
                else
                    ln_x = ln_x + sx;
                ln_err = ln_err + tclr_pkg::ERR_W'(ln_sgain);
            end
            ln_left = ln_left - 1'b1;
            if (ln_left == 0)
                ln_busy = 1'b0;
        end
    endtask

    // Driver: present queued beats, predict on each accepted one
    always @(posedge aclk) begin : driver
        line_beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                rasterize_beat(beat_on_bus);
            if (!s_tvalid || s_tready) begin
                if (beats_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 35)) begin
                    nb          = beats_pending.pop_front();
                    beat_on_bus = nb;
                    s_tvalid    <= 1'b1;
                    s_tuser     <= nb.mode;
                    s_tdata     <= {2'b00, nb.glyph, nb.fg, nb.to_y, nb.to_x,
                                    nb.from_y, nb.from_x};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Monitor: compare each result beat with the oldest predicted point
    always @(posedge aclk) begin : monitor
        grid_point_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (points_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat: expected none, got %0h",
                             $time, m_tdata);
                end else begin
                    e = points_due.pop_front();
                    check_field("point_x",      e.x,    m_tdata[6:0]);
                    check_field("point_y",      e.y,    m_tdata[12:7]);
                    check_field("cell_address", e.addr, m_tdata[23:13]);
                    check_field("cell_word",    e.word, m_tdata[39:24]);
                    check_field("off_screen",   e.off,  m_tuser);
                    check_field("last",         e.last, m_tlast);
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    task automatic push_load(input int ax, input int ay, input int bx, input int by,
                             input int fg, input int glyph);
        line_beat_t b;
        b.mode   = tclr_pkg::MODE_LOAD;
        b.from_x = tclr_pkg::X_W'(ax);
        b.from_y = tclr_pkg::Y_W'(ay);
        b.to_x   = tclr_pkg::X_W'(bx);
        b.to_y   = tclr_pkg::Y_W'(by);
        b.fg     = tclr_pkg::COLOR_W'(fg);
        b.glyph  = tclr_pkg::GLYPH_W'(glyph);
        beats_pending.push_back(b);
    endtask

    // Step beats carry random payload, which the block must ignore
    task automatic push_steps(input int n);
        line_beat_t b;
        repeat (n) begin
            b.mode   = tclr_pkg::MODE_STEP;
            b.from_x = tclr_pkg::X_W'($urandom);
            b.from_y = tclr_pkg::Y_W'($urandom);
            b.to_x   = tclr_pkg::X_W'($urandom);
            b.to_y   = tclr_pkg::Y_W'($urandom);
            b.fg     = tclr_pkg::COLOR_W'($urandom);
            b.glyph  = tclr_pkg::GLYPH_W'($urandom);
            beats_pending.push_back(b);
        end
    endtask

    function automatic int near(input int v, input int hi);
        int r;
        r = v + int'($urandom_range(0, 12)) - 6;
        if (r < 0)
            r = 0;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    // Mostly whole lines with random content; some cut short, overrun or noise
    task automatic random_phase(input int n_beats);
        int target, ax, ay, bx, by, pts, steps, r;
        line_beat_t b;
        target = beats_pending.size() + n_beats;
        while (beats_pending.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                b.mode   = tclr_pkg::mode_t'($urandom_range(0, 1));
                b.from_x = tclr_pkg::X_W'($urandom);
                b.from_y = tclr_pkg::Y_W'($urandom);
                b.to_x   = tclr_pkg::X_W'($urandom);
                b.to_y   = tclr_pkg::Y_W'($urandom);
                b.fg     = tclr_pkg::COLOR_W'($urandom);
                b.glyph  = tclr_pkg::GLYPH_W'($urandom);
                beats_pending.push_back(b);
            end else begin
                ax = $urandom_range(0, 127);
                ay = $urandom_range(0, 63);
                if (r < 55) begin
                    bx = near(ax, 127);
                    by = near(ay, 63);
                end else begin
                    bx = $urandom_range(0, 127);
                    by = $urandom_range(0, 63);
                end
                pts = ((ax > bx ? ax - bx : bx - ax) > (ay > by ? ay - by : by - ay) ?
                       (ax > bx ? ax - bx : bx - ax) : (ay > by ? ay - by : by - ay)) + 1;
                push_load(ax, ay, bx, by, $urandom_range(0, 15), $urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (r < 15)
                    steps = $urandom_range(0, pts);
                else if (r < 30)
                    steps = pts + $urandom_range(1, 3);
                else
                    steps = pts;
                push_steps(steps);
            end
        end
    endtask

    // Wait until the block has nothing left to do
    task automatic drain();
        do
            @(posedge aclk);
        while (beats_pending.size() != 0 || s_tvalid || points_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_background(input int v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= tclr_pkg::COLOR_W'(v);
        bg_model  = tclr_pkg::COLOR_W'(v);
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_background(15);

        // Directed: step while idle, then short lines over the corner cases
        push_steps(1);
        // equal endpoints, one point; then a step on an idle block
        push_load(5, 1, 5, 1, 15, 255);
        push_steps(2);
        // far corner, both axes decreasing, y major, off screen
        push_load(127, 63, 125, 60, 0, 0);
        push_steps(4);
        // row zero, x major, increasing
        push_load(0, 0, 2, 1, 10, 85);
        push_steps(3);
        // vertical line down the last column, abandoned by a new load
        push_load(79, 25, 79, 27, 5, 170);
        push_steps(2);
        push_load(0, 0, 127, 63, 0, 0);
        push_steps(2);
        push_load(1, 1, 1, 1, 3, 65);
        push_steps(1);
        drain();

        set_background(0);
        random_phase(250);
        drain();

        set_background($urandom_range(1, 14));
        calm = 1'b1;
        random_phase(200);
        drain();
        calm = 1'b0;

        // Long receiver hold-off while the sender keeps offering
        set_background(15);
        hold_req = 1'b1;
        random_phase(350);
        drain();

        set_background($urandom_range(0, 15));
        random_phase(200);
        drain();

        set_background($urandom_range(0, 15));
        random_phase(200);
        drain();
        repeat (10) @(posedge aclk);

        if (mismatches == 0 && points_due.size() == 0) begin
            $display("PASS text_cell_line_rasterizer");
        end else begin
            $display("FAIL text_cell_line_rasterizer");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAIL text_cell_line_rasterizer");
        $finish;
    end

endmodule
